// ----- rtl/bsfr_pkg.sv -----
package bsfr_pkg;

  // Control bytes on the line
  localparam logic [7:0] BYTE_BEGIN  = 8'hFE;
  localparam logic [7:0] BYTE_END    = 8'hFC;
  localparam logic [7:0] BYTE_ESCAPE = 8'hFD;
  localparam logic [7:0] ESC_XOR     = 8'h20;

  // Field widths
  localparam int BODY_W = 12;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [BODY_W-1:0] MAX_BODY_RESET = 12'd1024;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 16'd5000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd1;

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] OUT_PAYLOAD = 2'd0;
  localparam logic [1:0] OUT_GOOD    = 2'd1;
  localparam logic [1:0] OUT_ABORT   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
  localparam logic [2:0] ERR_NO_CHECK  = 3'd3;
  localparam logic [2:0] ERR_BAD_CHECK = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT   = 3'd5;

  // Receiver phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [7:0]        payload;
    logic [2:0]        error_code;
    logic [BODY_W-1:0] frame_length;
  } result_t;

  function automatic logic is_control(input logic [7:0] b);
    return (b == BYTE_BEGIN) || (b == BYTE_END) || (b == BYTE_ESCAPE);
  endfunction

endpackage

// ----- rtl/bsfr_in_if.sv -----
interface bsfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_in;

  modport source (output valid, output kind, output byte_in, input ready);
  modport sink (input valid, input kind, input byte_in, output ready);
endinterface

// ----- rtl/bsfr_out_if.sv -----
interface bsfr_out_if;
  import bsfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        out_kind;
  logic [7:0]        payload;
  logic [2:0]        error_code;
  logic [BODY_W-1:0] frame_length;

  modport source (output valid, output out_kind, output payload, output error_code,
                  output frame_length, input ready);
  modport sink (input valid, input out_kind, input payload, input error_code,
                input frame_length, output ready);
endinterface

// ----- rtl/bsfr_cfg_if.sv -----
interface bsfr_cfg_if;
  import bsfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bsfr_core.sv -----
module bsfr_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         kind,
  input  logic [7:0]                   byte_in,
  input  logic [bsfr_pkg::BODY_W-1:0]  max_body,
  input  logic [bsfr_pkg::TICK_W-1:0]  timeout_ticks,
  output logic                         res_valid,
  output bsfr_pkg::result_t            res
);
  import bsfr_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [7:0]        held_byte_r, held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [BODY_W-1:0] body_count_r, body_count_nxt;
  logic [TICK_W-1:0] idle_ticks_r, idle_ticks_nxt;

  logic [TICK_W:0]   idle_sum;
  logic [BODY_W:0]   count_sum;
  logic [7:0]        body_byte;
  logic              take;
  logic              in_frame;

  assign idle_sum  = {1'b0, idle_ticks_r} + {{TICK_W{1'b0}}, 1'b1};
  assign count_sum = {1'b0, body_count_r} + {{BODY_W{1'b0}}, 1'b1};
  assign in_frame  = (phase_r == PH_BODY) || (phase_r == PH_ESC);
  assign body_byte = (phase_r == PH_ESC) ? (byte_in ^ ESC_XOR) : byte_in;

  always_comb begin
    phase_nxt      = phase_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    body_count_nxt = body_count_r;
    idle_ticks_nxt = idle_ticks_r;
    res_valid      = 1'b0;
    res            = '0;
    take           = 1'b0;

    if (step) begin
      if (!in_frame) begin
        if (kind == KIND_BYTE && byte_in == BYTE_BEGIN) begin
          phase_nxt      = PH_BODY;
          held_valid_nxt = 1'b0;
          body_count_nxt = '0;
          idle_ticks_nxt = '0;
        end
      end else if (kind == KIND_TICK) begin
        if (idle_sum > {1'b0, timeout_ticks}) begin
          phase_nxt      = PH_HUNT;
          res_valid      = 1'b1;
          res.out_kind   = OUT_ABORT;
          res.error_code = ERR_TIMEOUT;
        end else begin
          idle_ticks_nxt = idle_sum[TICK_W-1:0];
        end
      end else begin
        idle_ticks_nxt = '0;
        if (phase_r == PH_ESC) begin
          if (is_control(byte_in)) begin
            phase_nxt      = PH_HUNT;
            res_valid      = 1'b1;
            res.out_kind   = OUT_ABORT;
            res.error_code = ERR_BAD_ESC;
          end else begin
            phase_nxt = PH_BODY;
            take      = 1'b1;
          end
        end else if (byte_in == BYTE_END) begin
          phase_nxt = PH_HUNT;
          res_valid = 1'b1;
          if (body_count_r == '0) begin
            res.out_kind   = OUT_ABORT;
            res.error_code = ERR_NO_CHECK;
          end else if (held_byte_r != 8'h00) begin
            res.out_kind   = OUT_ABORT;
            res.error_code = ERR_BAD_CHECK;
          end else begin
            res.out_kind     = OUT_GOOD;
            res.frame_length = body_count_r - {{(BODY_W-1){1'b0}}, 1'b1};
          end
        end else if (byte_in == BYTE_ESCAPE) begin
          phase_nxt = PH_ESC;
        end else begin
          take = 1'b1;
        end

        // decoded body byte; previous one goes out, so the check byte never does
        if (take) begin
          if (count_sum > {1'b0, max_body}) begin
            phase_nxt      = PH_HUNT;
            res_valid      = 1'b1;
            res.out_kind   = OUT_ABORT;
            res.error_code = ERR_TOO_BIG;
          end else begin
            body_count_nxt = count_sum[BODY_W-1:0];
            held_byte_nxt  = body_byte;
            held_valid_nxt = 1'b1;
            if (held_valid_r) begin
              res_valid    = 1'b1;
              res.out_kind = OUT_PAYLOAD;
              res.payload  = held_byte_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      held_valid_r <= 1'b0;
      body_count_r <= '0;
      idle_ticks_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      held_valid_r <= held_valid_nxt;
      body_count_r <= body_count_nxt;
      idle_ticks_r <= idle_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

// ----- rtl/byte_stuffed_frame_receiver.sv -----
// Channel  Dir  Transfer when        Payload
// in_bus   in   valid & ready        kind, byte_in
// out_bus  out  valid & ready        out_kind, payload, error_code, frame_length
// cfg_bus  in   valid & ready        index (0 max_body, 1 timeout_ticks), data
//
// One item per cycle while in_bus.ready is high; a result appears in the cycle after its input transfer.
// The decoder and its state sit in front of one output register, which is the
// only stage; in_bus.ready drops only while that register is full and stalled.
// Reset (rst_n low, synchronous) returns to hunting and reloads the registers
// with max_body 1024 and timeout_ticks 5000. cfg_bus is always ready.
module byte_stuffed_frame_receiver (
  input logic        clk,
  input logic        rst_n,
  bsfr_in_if.sink    in_bus,
  bsfr_out_if.source out_bus,
  bsfr_cfg_if.sink   cfg_bus
);
  import bsfr_pkg::*;

  // configuration registers
  logic [BODY_W-1:0] max_body_r;
  logic [TICK_W-1:0] timeout_ticks_r;

  // output register
  logic    out_valid_r;
  result_t out_res_r;

  logic    step;
  logic    res_valid;
  result_t res;

  // Accept while the output register is empty or drains this cycle.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign step         = in_bus.valid && in_bus.ready;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r      <= MAX_BODY_RESET;
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_MAX_BODY: max_body_r      <= cfg_bus.data[BODY_W-1:0];
        CFG_TIMEOUT:  timeout_ticks_r <= cfg_bus.data[TICK_W-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // Frame decoder: phase, held byte, counters; at most one result per item.
  bsfr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .kind          (in_bus.kind),
    .byte_in       (in_bus.byte_in),
    .max_body      (max_body_r),
    .timeout_ticks (timeout_ticks_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset; loaded on every accepted item that yields a result
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_kind     = out_res_r.out_kind;
  assign out_bus.payload      = out_res_r.payload;
  assign out_bus.error_code   = out_res_r.error_code;
  assign out_bus.frame_length = out_res_r.frame_length;

endmodule

// ----- rtl/bsfr_checker.sv -----
module bsfr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [7:0]                  payload,
  input logic [2:0]                  error_code,
  input logic [bsfr_pkg::BODY_W-1:0] frame_length
);
  import bsfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OUT_PAYLOAD |-> error_code == ERR_NONE && frame_length == '0)
    else $error("payload result carries error or length");

  a_good_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == OUT_GOOD |-> error_code == ERR_NONE && payload == 8'h00)
    else $error("good frame result carries error or payload");

  a_abort_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == OUT_PAYLOAD || out_kind == OUT_GOOD ||
      (out_kind == OUT_ABORT && error_code != ERR_NONE && error_code <= ERR_TIMEOUT &&
       frame_length == '0))
    else $error("bad result kind or error code");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_bus.ready),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_kind     (out_bus.out_kind),
  .payload      (out_bus.payload),
  .error_code   (out_bus.error_code),
  .frame_length (out_bus.frame_length)
);

// ----- sim/tb_byte_stuffed_frame_receiver.sv -----
module tb_byte_stuffed_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  // Spare register indexes; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on any channel
  localparam int DRAIN_SLACK    = 4;     // pause after draining a one-stage block
  localparam int LONG_HOLD      = 300;   // receiver hold-off for the fill test

  // Ways a random frame can be broken on purpose
  typedef enum int {
    FAULT_NONE,
    FAULT_BAD_CHECK,
    FAULT_BAD_ESC,
    FAULT_LONG_IDLE,
    FAULT_NO_END,
    FAULT_EMPTY,
    FAULT_OVERSIZE
  } fault_e;

  logic clk;
  logic rst_n;

  bsfr_in_if  in_bus ();
  bsfr_out_if out_bus ();
  bsfr_cfg_if cfg_bus ();

  byte_stuffed_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  // ---------------------------------------------------------------------------
  // Deframer predictor state, mirrors the block's registers
  // ---------------------------------------------------------------------------
  logic [1:0]        rx_phase;
  logic [7:0]        held_byte;
  logic              held_valid;
  logic [12:0]       body_count;
  logic [16:0]       idle_ticks;
  logic [BODY_W-1:0] max_body_q;
  logic [TICK_W-1:0] timeout_q;

  result_t expected_q[$];   // decoded bytes and frame verdicts still owed by the block
  result_t want;

  int mismatch_count = 0;
  int useful_items   = 0;   // transfers the deframer actually acts on
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int stalled_cycles = 0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_framing_byte(input logic [7:0] b);
    return (b == BYTE_BEGIN) || (b == BYTE_END) || (b == BYTE_ESCAPE);
  endfunction

  function automatic result_t make_result(input logic [1:0] k, input logic [7:0] p,
                                          input logic [2:0] e, input logic [BODY_W-1:0] n);
    result_t r;
    r.out_kind     = k;
    r.payload      = p;
    r.error_code   = e;
    r.frame_length = n;
    return r;
  endfunction

  function automatic void back_to_hunt();
    rx_phase   = PH_HUNT;
    held_byte  = 8'h00;
    held_valid = 1'b0;
    body_count = '0;
    idle_ticks = '0;
  endfunction

  function automatic void abort_frame(input logic [2:0] err);
    back_to_hunt();
    expected_q.push_back(make_result(OUT_ABORT, 8'h00, err, '0));
  endfunction

  // Payload leaves one byte behind so the check byte is never forwarded
  function automatic void take_body_byte(input logic [7:0] b);
    body_count = body_count + 13'd1;
    if (body_count > {1'b0, max_body_q}) begin
      abort_frame(ERR_TOO_BIG);
      return;
    end
    if (held_valid)
      expected_q.push_back(make_result(OUT_PAYLOAD, held_byte, ERR_NONE, '0));
    held_byte  = b;
    held_valid = 1'b1;
  endfunction

  function automatic void predict_rx(input logic k, input logic [7:0] b);
    logic [12:0] count;
    logic [7:0]  chk;
    // Hunting: only a begin byte matters, ticks and everything else are dropped
    if (rx_phase != PH_BODY && rx_phase != PH_ESC) begin
      if (k == KIND_BYTE && b == BYTE_BEGIN) begin
        back_to_hunt();
        rx_phase = PH_BODY;
      end
      return;
    end
    if (k == KIND_TICK) begin
      idle_ticks = idle_ticks + 17'd1;
      if (idle_ticks > {1'b0, timeout_q})
        abort_frame(ERR_TIMEOUT);
      return;
    end
    idle_ticks = '0;
    if (rx_phase == PH_ESC) begin
      if (is_framing_byte(b)) begin
        abort_frame(ERR_BAD_ESC);
      end else begin
        rx_phase = PH_BODY;
        take_body_byte(b ^ ESC_XOR);
      end
      return;
    end
    if (b == BYTE_END) begin
      count = body_count;
      chk   = held_byte;
      back_to_hunt();
      if (count == 13'd0)
        expected_q.push_back(make_result(OUT_ABORT, 8'h00, ERR_NO_CHECK, '0));
      else if (chk != 8'h00)
        expected_q.push_back(make_result(OUT_ABORT, 8'h00, ERR_BAD_CHECK, '0));
      else
        expected_q.push_back(make_result(OUT_GOOD, 8'h00, ERR_NONE, BODY_W'(count - 13'd1)));
    end else if (b == BYTE_ESCAPE) begin
      rx_phase = PH_ESC;
    end else begin
      take_body_byte(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatch_count < 30)
      $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_bus.out_kind));
      end else begin
        want = expected_q.pop_front();
        if (out_bus.out_kind !== want.out_kind)
          report_mismatch($sformatf("out_kind got %0d want %0d",
                                    out_bus.out_kind, want.out_kind));
        if (out_bus.payload !== want.payload)
          report_mismatch($sformatf("payload got %02h want %02h",
                                    out_bus.payload, want.payload));
        if (out_bus.error_code !== want.error_code)
          report_mismatch($sformatf("error_code got %0d want %0d",
                                    out_bus.error_code, want.error_code));
        if (out_bus.frame_length !== want.frame_length)
          report_mismatch($sformatf("frame_length got %0d want %0d",
                                    out_bus.frame_length, want.frame_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // One input transfer; valid stays up afterwards unless the next call idles
  task automatic send_item(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.kind    <= k;
    in_bus.byte_in <= b;
    do @(posedge clk); while (!in_bus.ready);
    if (rx_phase != PH_HUNT || (k == KIND_BYTE && b == BYTE_BEGIN))
      useful_items++;
    predict_rx(k, b);
  endtask

  // Drop valid, let every owed result come out, then a short pause
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Register writes only ever happen with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_MAX_BODY: max_body_q = data[BODY_W-1:0];
      CFG_TIMEOUT:  timeout_q  = data[TICK_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // Occasional tick runs that stay within the timeout
  task automatic maybe_ticks();
    if ($urandom_range(7) == 0)
      send_ticks($urandom_range((timeout_q < 3) ? timeout_q : 3));
  endtask

  // Body values lean on framing bytes and their escaped neighbors
  function automatic logic [7:0] pick_body_byte();
    if ($urandom_range(9) < 2) begin
      case ($urandom_range(5))
        0: return BYTE_BEGIN;
        1: return BYTE_END;
        2: return BYTE_ESCAPE;
        3: return 8'h00;
        4: return 8'hFF;
        default: return BYTE_ESCAPE ^ ESC_XOR;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Framing bytes must be escaped; others sometimes are, when that stays legal
  task automatic send_body_byte(input logic [7:0] b);
    if (is_framing_byte(b) || ($urandom_range(9) == 0 && !is_framing_byte(b ^ ESC_XOR))) begin
      send_item(KIND_BYTE, BYTE_ESCAPE);
      maybe_ticks();
      send_item(KIND_BYTE, b ^ ESC_XOR);
    end else begin
      send_item(KIND_BYTE, b);
    end
  endtask

  task automatic send_frame(input int len, input fault_e fault);
    int pos;
    int i;
    logic [7:0] b;
    pos = $urandom_range(len);
    send_item(KIND_BYTE, BYTE_BEGIN);
    for (i = 0; i < len; i++) begin
      if (i == pos && fault == FAULT_BAD_ESC) begin
        send_item(KIND_BYTE, BYTE_ESCAPE);
        case ($urandom_range(2))
          0: send_item(KIND_BYTE, BYTE_BEGIN);
          1: send_item(KIND_BYTE, BYTE_END);
          default: send_item(KIND_BYTE, BYTE_ESCAPE);
        endcase
      end
      if (i == pos && fault == FAULT_LONG_IDLE)
        send_ticks((timeout_q < 50) ? timeout_q + 1 : 6);
      maybe_ticks();
      if (i == len - 1)
        b = (fault == FAULT_BAD_CHECK) ? 8'($urandom_range(1, 255)) : 8'h00;
      else
        b = pick_body_byte();
      send_body_byte(b);
    end
    maybe_ticks();
    if (fault != FAULT_NO_END)
      send_item(KIND_BYTE, BYTE_END);
  endtask

  // Mostly short frames; now and then a longer one, up to just past max_body when it is small
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return $urandom_range(1, 8);
    if (r < 95)
      return $urandom_range(32);
    return (max_body_q <= 60) ? $urandom_range(max_body_q + 2) : $urandom_range(33, 80);
  endfunction

  // Well-formed frames dominate; the rest is broken frames and line noise
  task automatic run_traffic(input int n);
    int target;
    int r;
    int len;
    fault_e fault;
    target = useful_items + n;
    while (useful_items < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_frame(pick_len(), FAULT_NONE);
      end else if (r < 88) begin
        fault = fault_e'($urandom_range(FAULT_BAD_CHECK, FAULT_OVERSIZE));
        len = pick_len();
        if (fault == FAULT_EMPTY)
          len = 0;
        if (fault == FAULT_OVERSIZE && max_body_q <= 60)
          len = max_body_q + 1 + $urandom_range(2);
        send_frame(len, fault);
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hunting ignores ticks and stray end bytes; escapes decode; a begin byte
  // inside a body is plain data; the check byte may itself be escaped
  task automatic test_framing();
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_BYTE, BYTE_END);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, BYTE_ESCAPE);
    send_item(KIND_BYTE, BYTE_END ^ ESC_XOR);
    send_item(KIND_BYTE, BYTE_ESCAPE);
    send_item(KIND_BYTE, ESC_XOR);
    send_item(KIND_BYTE, BYTE_END);
  endtask

  // Empty body, nonzero check byte, escape followed by a framing byte
  task automatic test_frame_errors();
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, BYTE_END);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, BYTE_END);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, BYTE_ESCAPE);
    send_item(KIND_BYTE, BYTE_ESCAPE);
  endtask

  // Size limit (upper data bits must be dropped), zero limits, spare indexes
  task automatic test_register_limits();
    write_reg(CFG_MAX_BODY, 16'hF001);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h07);
    write_reg(CFG_MAX_BODY, 16'h0000);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_BYTE, 8'h00);
    write_reg(CFG_TIMEOUT, 16'h0000);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    send_item(KIND_BYTE, BYTE_BEGIN);
    send_item(KIND_TICK, 8'h00);
  endtask

  task automatic test_clean_link();
    set_idling(0, 0);
    write_reg(CFG_MAX_BODY, 16'(MAX_BODY_RESET));
    write_reg(CFG_TIMEOUT, TIMEOUT_RESET);
    run_traffic(350);
  endtask

  // Tiny limits so oversize and timeout aborts are common
  task automatic test_tight_limits();
    set_idling(63, 0);
    repeat (5) begin
      write_reg(CFG_MAX_BODY, 16'($urandom_range(12)));
      write_reg(CFG_TIMEOUT, 16'($urandom_range(3)));
      run_traffic(70);
    end
  endtask

  task automatic test_wide_limits();
    set_idling(0, 63);
    write_reg(CFG_MAX_BODY, 16'hFFFF);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    run_traffic(150);
    write_reg(CFG_MAX_BODY, 16'd60);
    write_reg(CFG_TIMEOUT, 16'd2);
    run_traffic(150);
  endtask

  task automatic test_mixed_settings();
    set_idling(6, 6);
    repeat (4) begin
      write_reg(CFG_MAX_BODY, {4'($urandom_range(15)), 12'($urandom_range(64))});
      write_reg(CFG_TIMEOUT, 16'($urandom_range(6)));
      run_traffic(100);
    end
  endtask

  // Receiver holds off while the sender keeps offering: input must stall
  task automatic test_backpressure_fill();
    set_idling(0, 0);
    hold_request = LONG_HOLD;
    repeat (4) send_frame(20, FAULT_NONE);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.kind    = KIND_BYTE;
    in_bus.byte_in = 8'h00;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CFG_MAX_BODY;
    cfg_bus.data   = '0;
    max_body_q     = MAX_BODY_RESET;
    timeout_q      = TIMEOUT_RESET;
    back_to_hunt();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_framing();
    test_frame_errors();
    test_register_limits();
    test_clean_link();
    test_tight_limits();
    test_wide_limits();
    test_backpressure_fill();
    test_mixed_settings();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
